// ===== rtl/aar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_pkg
// Types, widths and constants shared by the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam int AXIS_W       = 16;
  localparam int ANG_W        = 16;
  localparam int MAG_W        = 16;
  localparam int SQ_W         = 32;             // n2 = x*x + y*y + z*z
  localparam int RAD_W        = 48;             // n2 << 16
  localparam int NRM_W        = 24;             // norm in Q.8
  localparam int REM_W        = 27;             // sqrt partial remainder
  localparam int DREM_W       = 40;             // divider partial remainder
  localparam int QUO_W        = 16;             // unit magnitude, up to 32768
  localparam int U_W          = 17;             // signed unit component, Q1.15
  localparam int CW           = 34;             // CORDIC datapath
  localparam int CS_W         = 18;             // cos, sin, t
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [15:0]   ONE_Q14  = 16'sd16384;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [ANG_W-1:0]         turn_angle;
  } aar_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;
  } aar_out_t;

  // data carried past the norm and divide cells
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [ANG_W-1:0]      ang;
    logic                  zero;
  } aar_side_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [NRM_W-1:0] root;
    aar_side_t        side;
  } aar_sq_t;

  typedef struct packed {
    logic [2:0][DREM_W-1:0] rem;
    logic [2:0][QUO_W-1:0]  quo;
    logic [NRM_W-1:0]       nrm;
    aar_side_t              side;
  } aar_dv_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [2:0][U_W-1:0]  u;
    logic                 flip;
    logic                 zero;
  } aar_cr_t;

  typedef struct packed {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
    logic signed [CS_W-1:0] t;
    logic [2:0][U_W-1:0]    u;
    logic                   zero;
  } aar_pm_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis plus binary angle to a 3x3 rotation matrix in Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one axis (x, y, z, any
//   common scale) and a turn_angle (65536 per turn). Output channel
//   out_valid/out_stall/out_data carries the nine matrix entries, saturated
//   to +/-1.0, and zero_axis, set with the identity when the axis is zero.
//   A transfer happens on a rising edge with valid high and stall low.
// Stages: input register, square stage, 24 square-root cells, 16 divider
//   cells, CORDIC_STEPS CORDIC cells (capped at ATAN_LEN), one cos/sin
//   rounding stage, three matrix stages ending in the output register.
// Throughput: one transfer per cycle while the chain is not stalled; every
//   cell takes a new item each cycle that the chain advances.
// Stall: the whole chain advances together. While a result sits in the output
//   register and out_stall is high, every stage holds and in_stall is high;
//   empty stages upstream are not squeezed out.
// Reset: synchronous, active low, clears all stage valid bits; the pipe comes
//   up empty and accepts input on the first cycle after reset.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix import aar_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  aar_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output aar_out_t out_data
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input register and squares
  logic                  v0_r, v1_r;
  aar_in_t               in_r;
  aar_side_t             side0, side1_r;
  logic [2:0][SQ_W-1:0]  sq1_r;

  always_comb begin
    side0.neg  = {in_r.axis_z[AXIS_W-1], in_r.axis_y[AXIS_W-1], in_r.axis_x[AXIS_W-1]};
    side0.mag[0] = in_r.axis_x[AXIS_W-1] ? (~in_r.axis_x + 1'b1) : in_r.axis_x;
    side0.mag[1] = in_r.axis_y[AXIS_W-1] ? (~in_r.axis_y + 1'b1) : in_r.axis_y;
    side0.mag[2] = in_r.axis_z[AXIS_W-1] ? (~in_r.axis_z + 1'b1) : in_r.axis_z;
    side0.ang  = in_r.turn_angle;
    side0.zero = (in_r.axis_x == '0) && (in_r.axis_y == '0) && (in_r.axis_z == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r    <= in_data;
      side1_r <= side0;
      for (int k = 0; k < 3; k++) begin
        sq1_r[k] <= side0.mag[k] * side0.mag[k];
      end
    end
  end

  // square-root chain: nrm = floor(sqrt(n2 << 16))
  logic [NRM_W:0] sq_v;
  aar_sq_t        sq_d [NRM_W+1];
  logic [SQ_W-1:0] n2;

  always_comb begin
    n2              = sq1_r[0] + sq1_r[1] + sq1_r[2];
    sq_d[0].rad     = {n2, 16'b0};
    sq_d[0].rem     = '0;
    sq_d[0].root    = '0;
    sq_d[0].side    = side1_r;
  end
  assign sq_v[0] = v1_r;

  for (genvar i = 0; i < NRM_W; i++) begin : g_sqrt
    aar_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (sq_v[i]),
      .d_i   (sq_d[i]),
      .vld_o (sq_v[i+1]),
      .d_o   (sq_d[i+1])
    );
  end

  // divider chain: |v| * 2^23 / nrm, rounded
  logic [QUO_W:0] dv_v;
  aar_dv_t        dv_d [QUO_W+1];
  logic [NRM_W-1:0] nrm;

  always_comb begin
    nrm          = sq_d[NRM_W].root;
    dv_d[0].nrm  = nrm;
    dv_d[0].side = sq_d[NRM_W].side;
    dv_d[0].quo  = '0;
    for (int k = 0; k < 3; k++) begin
      dv_d[0].rem[k] = {1'b0, sq_d[NRM_W].side.mag[k], 23'b0}
                     + {{(DREM_W-NRM_W+1){1'b0}}, nrm[NRM_W-1:1]};
    end
  end
  assign dv_v[0] = sq_v[NRM_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    aar_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (dv_v[i]),
      .d_i   (dv_d[i]),
      .vld_o (dv_v[i+1]),
      .d_o   (dv_d[i+1])
    );
  end

  // CORDIC chain; angle folded to a quarter turn either side of zero
  logic [NSTEP:0]   cr_v;
  aar_cr_t          cr_d [NSTEP+1];
  logic [ANG_W-1:0] ang_f;
  aar_side_t        sd;

  always_comb begin
    sd          = dv_d[QUO_W].side;
    cr_d[0].flip = sd.ang[ANG_W-1] ^ sd.ang[ANG_W-2];
    ang_f       = sd.ang ^ {cr_d[0].flip, {(ANG_W-1){1'b0}}};
    cr_d[0].x   = GAIN_Q30;
    cr_d[0].y   = '0;
    cr_d[0].z   = {{(CW-ANG_W-16){ang_f[ANG_W-1]}}, ang_f, 16'b0};
    cr_d[0].zero = sd.zero;
    for (int k = 0; k < 3; k++) begin
      cr_d[0].u[k] = sd.neg[k] ? (~{1'b0, dv_d[QUO_W].quo[k]} + 1'b1)
                               : {1'b0, dv_d[QUO_W].quo[k]};
    end
  end
  assign cr_v[0] = dv_v[QUO_W];

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    aar_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (cr_v[i]),
      .d_i   (cr_d[i]),
      .vld_o (cr_v[i+1]),
      .d_o   (cr_d[i+1])
    );
  end

  // cos/sin to Q1.15 with clamp, t = 1 - cos
  logic                 pm_v_r;
  aar_pm_t              pm_r, pm_nxt;
  logic signed [CW-1:0] xf, yf;
  logic signed [CW:0]   xr, yr;

  function automatic logic signed [CS_W-1:0] clamp15(input logic signed [CW:0] v);
    logic signed [CS_W-1:0] q;
    if (v > (CW+1)'(32768)) begin
      q = CS_W'(32768);
    end else if (v < -(CW+1)'(32768)) begin
      q = -CS_W'(32768);
    end else begin
      q = v[CS_W-1:0];
    end
    return q;
  endfunction

  always_comb begin
    xf = cr_d[NSTEP].flip ? -cr_d[NSTEP].x : cr_d[NSTEP].x;
    yf = cr_d[NSTEP].flip ? -cr_d[NSTEP].y : cr_d[NSTEP].y;
    xr = ((CW+1)'(xf) + (CW+1)'(16384)) >>> 15;
    yr = ((CW+1)'(yf) + (CW+1)'(16384)) >>> 15;
    pm_nxt.c    = clamp15(xr);
    pm_nxt.s    = clamp15(yr);
    pm_nxt.t    = CS_W'(32768) - pm_nxt.c;
    pm_nxt.u    = cr_d[NSTEP].u;
    pm_nxt.zero = cr_d[NSTEP].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else if (adv) begin
      pm_v_r <= cr_v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm_r <= pm_nxt;
    end
  end

  aar_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (pm_v_r),
    .d_i   (pm_r),
    .vld_o (out_valid),
    .d_o   (out_data)
  );

  // zero axis always comes out as the identity
  a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_axis |->
      out_data.m00 == ONE_Q14 && out_data.m11 == ONE_Q14 &&
      out_data.m22 == ONE_Q14 && out_data.m01 == 16'sd0 && out_data.m12 == 16'sd0)
    else $error("zero axis result is not the identity");

  // saturation keeps the diagonal within +/-1.0 (m00 and m22 checked here)
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.m00 <= ONE_Q14 && out_data.m00 >= -ONE_Q14 &&
                  out_data.m22 <= ONE_Q14 && out_data.m22 >= -ONE_Q14)
    else $error("matrix entry outside +/-1.0");

  // input side stalls exactly when a held result blocks the chain
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall out of step with output hold");

  // pipe comes up empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !pm_v_r)
    else $error("valid after reset");

endmodule

// ===== rtl/aar_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_sqrt_cell
// One root bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module aar_sqrt_cell import aar_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    vld_i,
  input  aar_sq_t d_i,
  output logic    vld_o,
  output aar_sq_t d_o
);

  logic             vld_r;
  aar_sq_t          d_r;
  aar_sq_t          d_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    rem_sh = {d_i.rem[REM_W-3:0], d_i.rad[RAD_W-1 -: 2]};
    trial  = {{(REM_W-NRM_W-2){1'b0}}, d_i.root, 2'b01};
    ge     = (rem_sh >= trial);
    d_nxt       = d_i;
    d_nxt.rad   = {d_i.rad[RAD_W-3:0], 2'b00};
    d_nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
    d_nxt.root  = {d_i.root[NRM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== rtl/aar_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_div_cell
// One quotient bit of the three restoring dividers (axis / norm).
// ----------------------------------------------------------------------------
module aar_div_cell import aar_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    vld_i,
  input  aar_dv_t d_i,
  output logic    vld_o,
  output aar_dv_t d_o
);

  logic              vld_r;
  aar_dv_t           d_r;
  aar_dv_t           d_nxt;
  logic [DREM_W-1:0] dvs;
  logic [DREM_W-1:0] rem_n;
  logic              ge;

  always_comb begin
    d_nxt = d_i;
    dvs   = {1'b0, d_i.nrm, 15'b0};
    rem_n = '0;
    ge    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ge            = (d_i.rem[k] >= dvs);
      rem_n         = ge ? (d_i.rem[k] - dvs) : d_i.rem[k];
      d_nxt.rem[k]  = {rem_n[DREM_W-2:0], 1'b0};
      d_nxt.quo[k]  = {d_i.quo[k][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== rtl/aar_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_cordic_cell
// One rotation-mode CORDIC micro-rotation, shift fixed by its place.
// ----------------------------------------------------------------------------
module aar_cordic_cell import aar_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    vld_i,
  input  aar_cr_t d_i,
  output logic    vld_o,
  output aar_cr_t d_o
);

  localparam logic signed [CW-1:0] ATAN = $signed({2'b00, atan_entry(STEP)});

  logic                 vld_r;
  aar_cr_t              d_r;
  aar_cr_t              d_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    dx    = d_i.y >>> STEP;
    dy    = d_i.x >>> STEP;
    d_nxt = d_i;
    if (!d_i.z[CW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - ATAN;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== rtl/aar_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aar_matrix
// Rodrigues products, rounding to Q2.14 and saturation; last stage is the
// output register.
// ----------------------------------------------------------------------------
module aar_matrix import aar_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_i,
  input  aar_pm_t  d_i,
  output logic     vld_o,
  output aar_out_t d_o
);

  localparam int P_W = 2*U_W;        // u*u
  localparam int S_W = CS_W + U_W;   // s*u
  localparam int E_W = 56;

  // pair order: xx yy zz xy xz yz
  logic                        v1_r, v2_r, v3_r;
  logic signed [5:0][P_W-1:0]  p1_r;
  logic signed [2:0][S_W-1:0]  s1_r;
  logic signed [CS_W-1:0]      t1_r, c1_r;
  logic                        z1_r, z2_r;
  logic signed [5:0][E_W-1:0]  tp2_r;
  logic signed [2:0][E_W-1:0]  sp2_r;
  logic signed [E_W-1:0]       c2_r;
  aar_out_t                    o_r;
  aar_out_t                    o_nxt;

  function automatic logic signed [15:0] to_q14(input logic signed [E_W-1:0] e);
    logic signed [E_W-1:0] r;
    logic signed [15:0]    q;
    r = (e + (E_W'(1) <<< 30)) >>> 31;
    if (r > E_W'(16384)) begin
      q = ONE_Q14;
    end else if (r < -E_W'(16384)) begin
      q = -ONE_Q14;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: u*u and s*u
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= $signed(d_i.u[0]) * $signed(d_i.u[0]);
      p1_r[1] <= $signed(d_i.u[1]) * $signed(d_i.u[1]);
      p1_r[2] <= $signed(d_i.u[2]) * $signed(d_i.u[2]);
      p1_r[3] <= $signed(d_i.u[0]) * $signed(d_i.u[1]);
      p1_r[4] <= $signed(d_i.u[0]) * $signed(d_i.u[2]);
      p1_r[5] <= $signed(d_i.u[1]) * $signed(d_i.u[2]);
      for (int k = 0; k < 3; k++) begin
        s1_r[k] <= d_i.s * $signed(d_i.u[k]);
      end
      t1_r <= d_i.t;
      c1_r <= d_i.c;
      z1_r <= d_i.zero;
    end
  end

  // stage 2: t*u*u, scaled s*u and c
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        tp2_r[k] <= E_W'(t1_r) * E_W'($signed(p1_r[k]));
      end
      for (int k = 0; k < 3; k++) begin
        sp2_r[k] <= E_W'($signed(s1_r[k])) <<< 15;
      end
      c2_r <= E_W'(c1_r) <<< 30;
      z2_r <= z1_r;
    end
  end

  // stage 3: sums, round, saturate; identity for a zero axis
  always_comb begin
    o_nxt.m00 = to_q14(tp2_r[0] + c2_r);
    o_nxt.m01 = to_q14(tp2_r[3] - sp2_r[2]);
    o_nxt.m02 = to_q14(tp2_r[4] + sp2_r[1]);
    o_nxt.m10 = to_q14(tp2_r[3] + sp2_r[2]);
    o_nxt.m11 = to_q14(tp2_r[1] + c2_r);
    o_nxt.m12 = to_q14(tp2_r[5] - sp2_r[0]);
    o_nxt.m20 = to_q14(tp2_r[4] - sp2_r[1]);
    o_nxt.m21 = to_q14(tp2_r[5] + sp2_r[0]);
    o_nxt.m22 = to_q14(tp2_r[2] + c2_r);
    o_nxt.zero_axis = z2_r;
    if (z2_r) begin
      o_nxt     = '0;
      o_nxt.m00 = ONE_Q14;
      o_nxt.m11 = ONE_Q14;
      o_nxt.m22 = ONE_Q14;
      o_nxt.zero_axis = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign vld_o = v3_r;
  assign d_o   = o_r;

endmodule

// ===== test/axis_angle_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_tb
// Drives axis/angle transfers with random idle and stall bursts, predicts each
// rotation matrix in fixed point and checks every result in order.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_tb import aar_pkg::*;;

  localparam int  STEPS     = CORDIC_STEPS_DEF;
  localparam int  LATENCY   = 46 + STEPS;
  localparam int  N_RANDOM  = 1030;
  localparam int  CALM_TAIL = 150;     // last items run with no idling
  localparam longint CYCLE_LIMIT = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  aar_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  aar_out_t out_data;

  int     n_errors;
  longint n_cycles;
  bit     calm;          // no idling on either side

  axis_angle_rotation_matrix #(.CORDIC_STEPS(STEPS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  task automatic report(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, n_cycles);
  endtask

  // ------------------------------------------------------------------------
  // Fixed-point matrix predictor
  // ------------------------------------------------------------------------
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;      // arithmetic shift = floor for signed longint
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint unit_comp(longint v, longint nrm);
    longint mag, q;
    mag = v < 0 ? -v : v;
    q = ((mag << 23) + nrm / 2) / nrm;
    if (q > 32768) q = 32768;
    return v < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] to_q14(longint e);
    return 16'(clip(floor_shift(e + (64'sd1 << 30), 31), -16384, 16384));
  endfunction

  function automatic longint atan_turn(int i);
    longint tab [24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    return tab[i];
  endfunction

  function automatic aar_out_t rotation_matrix(aar_in_t a);
    aar_out_t r;
    longint x, y, z, n2, nrm, ux, uy, uz, ang, cx, cy, dx, dy, c, s, t, c45;
    longint txy, txz, tyz, sx, sy, sz;
    logic [15:0] folded;
    bit flip;
    int steps;
    x = a.axis_x; y = a.axis_y; z = a.axis_z;
    n2 = x * x + y * y + z * z;
    r = '0;
    if (n2 == 0) begin
      r.m00 = ONE_Q14; r.m11 = ONE_Q14; r.m22 = ONE_Q14;
      r.zero_axis = 1'b1;
      return r;
    end
    nrm = int_sqrt(longint'(n2) << 16);
    ux = unit_comp(x, nrm); uy = unit_comp(y, nrm); uz = unit_comp(z, nrm);
    folded = a.turn_angle;
    flip = (folded >= 16'h4000 && folded < 16'hC000);
    if (flip) folded = folded - 16'h8000;
    ang = longint'($signed(folded)) * 65536;
    cx = 652032874; cy = 0;
    steps = STEPS > 24 ? 24 : STEPS;
    for (int k = 0; k < steps; k++) begin
      dx = floor_shift(cy, k); dy = floor_shift(cx, k);
      if (ang >= 0) begin
        cx -= dx; cy += dy; ang -= atan_turn(k);
      end else begin
        cx += dx; cy -= dy; ang += atan_turn(k);
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    c = clip(floor_shift(cx + 16384, 15), -32768, 32768);
    s = clip(floor_shift(cy + 16384, 15), -32768, 32768);
    t = 32768 - c;
    c45 = c <<< 30;
    txy = t * ux * uy; txz = t * ux * uz; tyz = t * uy * uz;
    sx = s * ux * 32768; sy = s * uy * 32768; sz = s * uz * 32768;
    r.m00 = to_q14(t * ux * ux + c45);
    r.m01 = to_q14(txy - sz);
    r.m02 = to_q14(txz + sy);
    r.m10 = to_q14(txy + sz);
    r.m11 = to_q14(t * uy * uy + c45);
    r.m12 = to_q14(tyz - sx);
    r.m20 = to_q14(txz - sy);
    r.m21 = to_q14(tyz + sx);
    r.m22 = to_q14(t * uz * uz + c45);
    r.zero_axis = 1'b0;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Scoreboard: expected matrices in transfer order
  // ------------------------------------------------------------------------
  class matrix_board;
    aar_out_t pending[$];

    function void note_input(aar_in_t a);
      pending.push_back(rotation_matrix(a));
    endfunction

    task check_result(aar_out_t got);
      aar_out_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.m00 != want.m00) report("m00", got.m00, want.m00);
      if (got.m01 != want.m01) report("m01", got.m01, want.m01);
      if (got.m02 != want.m02) report("m02", got.m02, want.m02);
      if (got.m10 != want.m10) report("m10", got.m10, want.m10);
      if (got.m11 != want.m11) report("m11", got.m11, want.m11);
      if (got.m12 != want.m12) report("m12", got.m12, want.m12);
      if (got.m20 != want.m20) report("m20", got.m20, want.m20);
      if (got.m21 != want.m21) report("m21", got.m21, want.m21);
      if (got.m22 != want.m22) report("m22", got.m22, want.m22);
      if (got.zero_axis != want.zero_axis)
        report("zero_axis", got.zero_axis, want.zero_axis);
    endtask
  endclass

  matrix_board board = new();

  // Sample both channels at the rising edge; inputs move on the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_input(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", board.pending.size());
      $display("[axis_angle_rotation_matrix] ERROR");
      $finish;
    end
  end

  // Receiver stall: random bursts, quiet stretches between them.
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One transfer; held stable until accepted, then maybe an idle burst.
  task automatic send_axis(input logic signed [15:0] ax, input logic signed [15:0] ay,
                           input logic signed [15:0] az, input logic [15:0] ang);
    aar_in_t item;
    int gap;
    item.axis_x = ax; item.axis_y = ay; item.axis_z = az; item.turn_angle = ang;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      in_data  <= aar_in_t'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'(int'($urandom_range(0, 8)) - 4);   // tiny scale
      3:       return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 7)) * 16'h2000;  // multiples of 45 deg
      1:       return 16'h4000 + 16'($urandom_range(0, 2)) - 16'd1;  // fold boundary
      2:       return 16'hC000 + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ax, ay, az;
    n_errors  = 0;
    n_cycles  = 0;
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero axis, extremes, fold edges, principal axes
    send_axis(0, 0, 0, 16'h1234);
    send_axis(0, 0, 0, 16'h0000);
    send_axis(16'sh7FFF, 0, 0, 16'h4000);
    send_axis(0, 16'sh8000, 0, 16'h8000);
    send_axis(0, 0, 1, 16'hC000);
    send_axis(16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
    send_axis(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h3FFF);
    send_axis(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hBFFF);
    send_axis(1, 1, 1, 16'h2000);
    send_axis(-1, 0, 0, 16'h0001);
    send_axis(0, -1, 0, 16'h6000);
    send_axis(0, 0, -1, 16'hA000);
    send_axis(3, 4, 0, 16'hE000);
    send_axis(16'sh8000, 1, 0, 16'h5555);
    send_axis(1, 0, 16'sh7FFF, 16'hAAAA);
    send_axis(-5, 7, -11, 16'h8001);
    send_axis(100, -200, 300, 16'h7FFF);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      ax = pick_axis(); ay = pick_axis(); az = pick_axis();
      if ($urandom_range(0, 39) == 0) begin
        ax = 0; ay = 0; az = 0;
      end
      send_axis(ax, ay, az, pick_angle());
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("[axis_angle_rotation_matrix] OK");
    end else begin
      $display("[axis_angle_rotation_matrix] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aar_pkg.sv
rtl/aar_sqrt_cell.sv
rtl/aar_div_cell.sv
rtl/aar_cordic_cell.sv
rtl/aar_matrix.sv
rtl/axis_angle_rotation_matrix.sv
test/axis_angle_rotation_matrix_tb.sv
